@@ src/i2c_ram_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package i2c_ram_pkg;

  localparam int unsigned TickCountWidth = 8;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] CfgDevAddr = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgTpp     = 1'd1;

  localparam logic [6:0] DevAddrReset = 7'd104;
  localparam logic [7:0] TppReset     = 8'd4;

  localparam int unsigned StepW = 4;

  localparam logic [StepW-1:0] StepIdle    = 4'd0;
  localparam logic [StepW-1:0] StepStart   = 4'd1;
  localparam logic [StepW-1:0] StepAddrW   = 4'd2;
  localparam logic [StepW-1:0] StepReg     = 4'd3;
  localparam logic [StepW-1:0] StepData    = 4'd4;
  localparam logic [StepW-1:0] StepRestart = 4'd5;
  localparam logic [StepW-1:0] StepAddrR   = 4'd6;
  localparam logic [StepW-1:0] StepRead    = 4'd7;
  localparam logic [StepW-1:0] StepStop    = 4'd8;

  localparam logic OpWrite = 1'b0;
  localparam logic OpRead  = 1'b1;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy;
    logic       done;
    logic [7:0] read_data;
    logic       nack_seen;
  } result_t;

endpackage

`default_nettype wire

@@ src/i2c_register_access_master.sv @@
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+---------------------------------------------
// in       | input     | in_valid_i/in_stall_o   | request_valid, opcode, register_address,
//          |           |                        | write_data, sda_sample (one bus tick)
// out      | output    | out_valid_o/out_stall_i | scl_level, sda_pull_low, busy_res, done_res,
//          |           |                        | read_data, nack_seen (one per tick)
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// one tick per clock cycle while in_stall_o is low: the bus sequencer state and the result
// are computed in one combinational pass from the sequencer registers and the incoming tick.
// results sit in an output register backed by a one-entry skid register, so a tick is
// still taken while one result waits; in_stall_o rises only when both are full.
// reset (rst_ni low, asynchronous) puts the sequencer in idle and loads the register
// defaults: device address 104, four ticks per quarter phase.
`timescale 1ns / 1ps
`default_nettype none

module i2c_register_access_master #(
  parameter int unsigned TICK_COUNT_WIDTH = i2c_ram_pkg::TickCountWidth
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,

  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire                                request_valid_i,
  input  wire                                opcode_i,
  input  wire  [7:0]                         register_address_i,
  input  wire  [7:0]                         write_data_i,
  input  wire                                sda_sample_i,

  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic                               scl_level_o,
  output logic                               sda_pull_low_o,
  output logic                               busy_res_o,
  output logic                               done_res_o,
  output logic [7:0]                         read_data_o,
  output logic                               nack_seen_o,

  input  wire                                cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire  [i2c_ram_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire  [i2c_ram_pkg::CfgDataW-1:0]   cfg_data_i
);

  localparam int unsigned TcW  = TICK_COUNT_WIDTH;
  // compare width covers both the counter and the 8-bit phase length, plus carry
  localparam int unsigned CmpW = ((TcW > 8) ? TcW : 8) + 1;

  // configuration registers
  logic [6:0] dev_addr_q;
  logic [7:0] tpp_q;

  // sequencer state
  logic [i2c_ram_pkg::StepW-1:0] step_q, step_d;
  logic [1:0]                    quarter_q, quarter_d;
  logic [3:0]                    bit_cnt_q, bit_cnt_d;
  logic [TcW-1:0]                tick_q, tick_d;
  logic [7:0]                    shift_q, shift_d;
  logic                          op_q, op_d;
  logic [7:0]                    reg_q, reg_d;
  logic [7:0]                    data_q, data_d;
  logic                          ack_fault_q, ack_fault_d;

  // output register and skid register
  logic                    out_valid_q, out_valid_d;
  logic                    skid_valid_q, skid_valid_d;
  i2c_ram_pkg::result_t    out_q, out_d;
  i2c_ram_pkg::result_t    skid_q, skid_d;
  i2c_ram_pkg::result_t    res;

  logic in_fire;
  logic out_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = skid_valid_q;
  assign in_fire     = in_valid_i & ~in_stall_o;
  assign out_fire    = out_valid_q & ~out_stall_i;

  // shift register contents on entry into a step
  function automatic logic [7:0] entry_shift(
    input logic [i2c_ram_pkg::StepW-1:0] target,
    input logic [6:0]                    dev,
    input logic [7:0]                    regaddr,
    input logic [7:0]                    wdata,
    input logic [7:0]                    cur
  );
    logic [7:0] val;
    begin
      case (target)
        i2c_ram_pkg::StepAddrW: val = {dev, 1'b0};
        i2c_ram_pkg::StepReg:   val = regaddr;
        i2c_ram_pkg::StepData:  val = wdata;
        i2c_ram_pkg::StepAddrR: val = {dev, 1'b1};
        i2c_ram_pkg::StepRead:  val = 8'd0;
        default:                val = cur;
      endcase
      return val;
    end
  endfunction

  // sequencer: advances by one tick for each accepted input transfer (in_fire)
  always_comb begin
    logic [i2c_ram_pkg::StepW-1:0] s;
    logic [i2c_ram_pkg::StepW-1:0] nxt;
    logic                          active;
    logic                          run;
    logic                          byte_step;
    logic                          phase_end;
    logic                          advance;
    logic [7:0]                    tpp;
    logic [CmpW-1:0]               tick_inc;

    step_d      = step_q;
    quarter_d   = quarter_q;
    bit_cnt_d   = bit_cnt_q;
    tick_d      = tick_q;
    shift_d     = shift_q;
    op_d        = op_q;
    reg_d       = reg_q;
    data_d      = data_q;
    ack_fault_d = ack_fault_q;

    res.scl_level    = 1'b1;
    res.sda_pull_low = 1'b0;
    res.busy         = 1'b0;
    res.done         = 1'b0;
    res.read_data    = 8'd0;
    res.nack_seen    = 1'b0;

    nxt       = i2c_ram_pkg::StepIdle;
    advance   = 1'b0;
    phase_end = 1'b0;
    tick_inc  = '0;
    tpp       = 8'd1;

    active = (step_q != i2c_ram_pkg::StepIdle) && (step_q <= i2c_ram_pkg::StepStop);
    s      = step_q;
    run    = active;

    if (!active) begin
      step_d = i2c_ram_pkg::StepIdle;
      if (request_valid_i) begin
        op_d        = opcode_i;
        reg_d       = register_address_i;
        data_d      = write_data_i;
        ack_fault_d = 1'b0;
        s           = i2c_ram_pkg::StepStart;
        step_d      = i2c_ram_pkg::StepStart;
        quarter_d   = 2'd0;
        bit_cnt_d   = 4'd0;
        tick_d      = '0;
        run         = 1'b1;
      end
    end

    byte_step = (s == i2c_ram_pkg::StepAddrW) || (s == i2c_ram_pkg::StepReg) ||
                (s == i2c_ram_pkg::StepData)  || (s == i2c_ram_pkg::StepAddrR) ||
                (s == i2c_ram_pkg::StepRead);

    if (run) begin
      res.busy = 1'b1;

      if ((s == i2c_ram_pkg::StepStart) || (s == i2c_ram_pkg::StepRestart)) begin
        res.scl_level    = (quarter_d == 2'd1) || (quarter_d == 2'd2);
        res.sda_pull_low = quarter_d[1];
      end else if (s == i2c_ram_pkg::StepStop) begin
        res.scl_level    = (quarter_d != 2'd0);
        res.sda_pull_low = ~quarter_d[1];
      end else begin
        res.scl_level = (quarter_d == 2'd1) || (quarter_d == 2'd2);
        if (!bit_cnt_d[3] && (s != i2c_ram_pkg::StepRead)) begin
          res.sda_pull_low = ~shift_d[7];
        end
        // slave bits and acknowledges are sampled on the first tick of quarter 2
        if ((quarter_d == 2'd2) && (tick_d == '0)) begin
          if (bit_cnt_d[3]) begin
            if ((s != i2c_ram_pkg::StepRead) && sda_sample_i) begin
              ack_fault_d = 1'b1;
            end
          end else if (s == i2c_ram_pkg::StepRead) begin
            shift_d = {shift_d[6:0], sda_sample_i};
          end
        end
      end

      tpp       = (tpp_q == 8'd0) ? 8'd1 : tpp_q;
      tick_inc  = CmpW'(tick_d) + CmpW'(1);
      phase_end = (tick_inc >= CmpW'(tpp)) || (&tick_d);

      if (!phase_end) begin
        tick_d = tick_d + TcW'(1);
      end else begin
        tick_d = '0;
        if (quarter_d != 2'd3) begin
          quarter_d = quarter_d + 2'd1;
        end else begin
          quarter_d = 2'd0;
          if (byte_step) begin
            if (!bit_cnt_d[3]) begin
              if (s != i2c_ram_pkg::StepRead) begin
                shift_d = {shift_d[6:0], 1'b0};
              end
              bit_cnt_d = bit_cnt_d + 4'd1;
            end else begin
              advance = 1'b1;
              case (s)
                i2c_ram_pkg::StepAddrW: nxt = i2c_ram_pkg::StepReg;
                i2c_ram_pkg::StepReg:   nxt = (op_d == i2c_ram_pkg::OpRead) ?
                                              i2c_ram_pkg::StepRestart :
                                              i2c_ram_pkg::StepData;
                i2c_ram_pkg::StepAddrR: nxt = i2c_ram_pkg::StepRead;
                default:                nxt = i2c_ram_pkg::StepStop;
              endcase
            end
          end else if (s == i2c_ram_pkg::StepStart) begin
            advance = 1'b1;
            nxt     = i2c_ram_pkg::StepAddrW;
          end else if (s == i2c_ram_pkg::StepRestart) begin
            advance = 1'b1;
            nxt     = i2c_ram_pkg::StepAddrR;
          end else begin
            res.done      = 1'b1;
            res.read_data = (op_d == i2c_ram_pkg::OpRead) ? shift_d : 8'd0;
            res.nack_seen = ack_fault_d;
            step_d        = i2c_ram_pkg::StepIdle;
            bit_cnt_d     = 4'd0;
          end
        end
      end

      if (advance) begin
        step_d    = nxt;
        bit_cnt_d = 4'd0;
        quarter_d = 2'd0;
        tick_d    = '0;
        shift_d   = entry_shift(nxt, dev_addr_q, reg_d, data_d, shift_d);
      end
    end
  end

  // output register with skid
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (out_fire || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = in_fire;
      end
    end else if (in_fire) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q   <= i2c_ram_pkg::DevAddrReset;
      tpp_q        <= i2c_ram_pkg::TppReset;
      step_q       <= i2c_ram_pkg::StepIdle;
      quarter_q    <= 2'd0;
      bit_cnt_q    <= 4'd0;
      tick_q       <= '0;
      shift_q      <= 8'd0;
      op_q         <= 1'b0;
      reg_q        <= 8'd0;
      data_q       <= 8'd0;
      ack_fault_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          i2c_ram_pkg::CfgDevAddr: dev_addr_q <= cfg_data_i[6:0];
          i2c_ram_pkg::CfgTpp:     tpp_q      <= cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        step_q      <= step_d;
        quarter_q   <= quarter_d;
        bit_cnt_q   <= bit_cnt_d;
        tick_q      <= tick_d;
        shift_q     <= shift_d;
        op_q        <= op_d;
        reg_q       <= reg_d;
        data_q      <= data_d;
        ack_fault_q <= ack_fault_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o    = out_valid_q;
  assign scl_level_o    = out_q.scl_level;
  assign sda_pull_low_o = out_q.sda_pull_low;
  assign busy_res_o     = out_q.busy;
  assign done_res_o     = out_q.done;
  assign read_data_o    = out_q.read_data;
  assign nack_seen_o    = out_q.nack_seen;

  // skid entry only fills behind a held output
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register valid without output register");

  // a finishing tick always belongs to a transaction
  a_done_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> busy_res_o)
    else $error("done without busy");

  // received data and nack only show on the done tick
  a_data_on_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !done_res_o) |-> (read_data_o == 8'd0 && !nack_seen_o))
    else $error("read data or nack outside done tick");

  // while idle the bus lines stay released
  a_idle_released : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> (scl_level_o && !sda_pull_low_o))
    else $error("bus driven while idle");

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps

module tb;

  localparam int unsigned StuckLimit = 2000;
  localparam int unsigned MaxPrinted = 100;

  typedef enum int {SdaSlave, SdaNoise, SdaHigh, SdaLow, SdaFlaky} sda_mode_e;

  class bus_level_checker;
    logic [6:0]                             dev_addr;
    logic [7:0]                             tpp;
    logic [i2c_ram_pkg::StepW-1:0]          step;
    logic [1:0]                             quarter;
    logic [3:0]                             bit_cnt;
    logic [i2c_ram_pkg::TickCountWidth-1:0] tick_cnt;
    logic [7:0]                             shift;
    logic                                   held_op;
    logic [7:0]                             held_reg;
    logic [7:0]                             held_data;
    logic                                   ack_fault;
    i2c_ram_pkg::result_t                   expected_levels[$];
    int unsigned                            errors;

    function new();
      dev_addr  = i2c_ram_pkg::DevAddrReset;
      tpp       = i2c_ram_pkg::TppReset;
      step      = i2c_ram_pkg::StepIdle;
      quarter   = '0;
      bit_cnt   = '0;
      tick_cnt  = '0;
      shift     = '0;
      held_op   = i2c_ram_pkg::OpWrite;
      held_reg  = '0;
      held_data = '0;
      ack_fault = 1'b0;
      errors    = 0;
    endfunction

    function void set_cfg(logic [i2c_ram_pkg::CfgIdxW-1:0] idx,
                          logic [i2c_ram_pkg::CfgDataW-1:0] data);
      if (idx == i2c_ram_pkg::CfgDevAddr) dev_addr = data[6:0];
      else tpp = data;
    endfunction

    function int pending();
      return expected_levels.size();
    endfunction

    function bit seq_idle();
      return step == i2c_ram_pkg::StepIdle;
    endfunction

    function bit byte_step(logic [i2c_ram_pkg::StepW-1:0] s);
      return s == i2c_ram_pkg::StepAddrW || s == i2c_ram_pkg::StepReg ||
             s == i2c_ram_pkg::StepData || s == i2c_ram_pkg::StepAddrR ||
             s == i2c_ram_pkg::StepRead;
    endfunction

    // slot where the slave answers a byte sent by the master
    function bit ack_slot();
      return byte_step(step) && step != i2c_ram_pkg::StepRead && bit_cnt == 4'd8;
    endfunction

    function void enter_step(logic [i2c_ram_pkg::StepW-1:0] s);
      step     = s;
      bit_cnt  = '0;
      quarter  = '0;
      tick_cnt = '0;
      case (s)
        i2c_ram_pkg::StepAddrW: shift = {dev_addr, 1'b0};
        i2c_ram_pkg::StepReg:   shift = held_reg;
        i2c_ram_pkg::StepData:  shift = held_data;
        i2c_ram_pkg::StepAddrR: shift = {dev_addr, 1'b1};
        i2c_ram_pkg::StepRead:  shift = 8'h00;
        default: ;
      endcase
    endfunction

    function void note_tick(bit req, bit op, logic [7:0] ra, logic [7:0] wd, bit sda);
      i2c_ram_pkg::result_t          r;
      logic [i2c_ram_pkg::StepW-1:0] s;
      logic [1:0]                    q;
      int unsigned                   lim;
      int unsigned                   tc;
      r = '0;
      r.scl_level = 1'b1;
      if (step == i2c_ram_pkg::StepIdle || step > i2c_ram_pkg::StepStop) begin
        step = i2c_ram_pkg::StepIdle;
        if (!req) begin
          expected_levels.push_back(r);
          return;
        end
        held_op   = op;
        held_reg  = ra;
        held_data = wd;
        ack_fault = 1'b0;
        enter_step(i2c_ram_pkg::StepStart);
      end
      s = step;
      q = quarter;
      r.busy = 1'b1;
      if (s == i2c_ram_pkg::StepStart || s == i2c_ram_pkg::StepRestart) begin
        r.scl_level    = (q == 2'd1 || q == 2'd2);
        r.sda_pull_low = (q >= 2'd2);
      end else if (s == i2c_ram_pkg::StepStop) begin
        r.scl_level    = (q != 2'd0);
        r.sda_pull_low = (q <= 2'd1);
      end else begin
        r.scl_level    = (q == 2'd1 || q == 2'd2);
        r.sda_pull_low = (bit_cnt < 4'd8 && s != i2c_ram_pkg::StepRead) ? !shift[7] : 1'b0;
        // slave bits are sampled on the first tick of quarter two
        if (q == 2'd2 && tick_cnt == '0) begin
          if (bit_cnt == 4'd8) begin
            if (s != i2c_ram_pkg::StepRead && sda) ack_fault = 1'b1;
          end else if (s == i2c_ram_pkg::StepRead) begin
            shift = {shift[6:0], sda};
          end
        end
      end
      lim = (tpp == 8'd0) ? 1 : tpp;
      tc  = tick_cnt;
      if (tc + 1 < lim && tick_cnt != '1) begin
        tick_cnt = tick_cnt + 1'b1;
      end else begin
        tick_cnt = '0;
        if (q != 2'd3) begin
          quarter = q + 2'd1;
        end else begin
          quarter = '0;
          if (byte_step(s)) begin
            if (bit_cnt < 4'd8) begin
              if (s != i2c_ram_pkg::StepRead) shift = shift << 1;
              bit_cnt = bit_cnt + 4'd1;
            end else begin
              case (s)
                i2c_ram_pkg::StepAddrW: enter_step(i2c_ram_pkg::StepReg);
                i2c_ram_pkg::StepReg:
                  enter_step(held_op == i2c_ram_pkg::OpRead ? i2c_ram_pkg::StepRestart :
                                                              i2c_ram_pkg::StepData);
                i2c_ram_pkg::StepAddrR: enter_step(i2c_ram_pkg::StepRead);
                default:                enter_step(i2c_ram_pkg::StepStop);
              endcase
            end
          end else if (s == i2c_ram_pkg::StepStart) begin
            enter_step(i2c_ram_pkg::StepAddrW);
          end else if (s == i2c_ram_pkg::StepRestart) begin
            enter_step(i2c_ram_pkg::StepAddrR);
          end else begin
            r.done      = 1'b1;
            r.read_data = (held_op == i2c_ram_pkg::OpRead) ? shift : 8'h00;
            r.nack_seen = ack_fault;
            step        = i2c_ram_pkg::StepIdle;
            bit_cnt     = '0;
          end
        end
      end
      expected_levels.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(i2c_ram_pkg::result_t got);
      i2c_ram_pkg::result_t want;
      if (expected_levels.size() == 0) begin
        report("result with no tick waiting");
        return;
      end
      want = expected_levels.pop_front();
      if (got.scl_level !== want.scl_level)
        report($sformatf("scl_level got %b want %b", got.scl_level, want.scl_level));
      if (got.sda_pull_low !== want.sda_pull_low)
        report($sformatf("sda_pull_low got %b want %b", got.sda_pull_low,
                         want.sda_pull_low));
      if (got.busy !== want.busy)
        report($sformatf("busy_res got %b want %b", got.busy, want.busy));
      if (got.done !== want.done)
        report($sformatf("done_res got %b want %b", got.done, want.done));
      if (got.read_data !== want.read_data)
        report($sformatf("read_data got %h want %h", got.read_data, want.read_data));
      if (got.nack_seen !== want.nack_seen)
        report($sformatf("nack_seen got %b want %b", got.nack_seen, want.nack_seen));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                             in_valid_i         = 1'b0;
  logic                             in_stall_o;
  logic                             request_valid_i    = 1'b0;
  logic                             opcode_i           = i2c_ram_pkg::OpWrite;
  logic [7:0]                       register_address_i = '0;
  logic [7:0]                       write_data_i       = '0;
  logic                             sda_sample_i       = 1'b0;
  logic                             out_valid_o;
  logic                             out_stall_i        = 1'b0;
  logic                             scl_level_o;
  logic                             sda_pull_low_o;
  logic                             busy_res_o;
  logic                             done_res_o;
  logic [7:0]                       read_data_o;
  logic                             nack_seen_o;
  logic                             cfg_valid_i        = 1'b0;
  logic                             cfg_ready_o;
  logic [i2c_ram_pkg::CfgIdxW-1:0]  cfg_index_i        = i2c_ram_pkg::CfgDevAddr;
  logic [i2c_ram_pkg::CfgDataW-1:0] cfg_data_i         = '0;

  int unsigned cyc          = 0;
  int unsigned stuck_cycles = 0;
  wire         quiet        = (cyc % 600) >= 400;

  bus_level_checker levels = new();

  i2c_register_access_master u_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .request_valid_i,
    .opcode_i,
    .register_address_i,
    .write_data_i,
    .sda_sample_i,
    .out_valid_o,
    .out_stall_i,
    .scl_level_o,
    .sda_pull_low_o,
    .busy_res_o,
    .done_res_o,
    .read_data_o,
    .nack_seen_o,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      levels.check_result({scl_level_o, sda_pull_low_o, busy_res_o, done_res_o, read_data_o,
                           nack_seen_o});
    out_stall_i <= !quiet && ($urandom_range(99) < 16);
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= StuckLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  function automatic bit pick_sda(sda_mode_e mode);
    case (mode)
      SdaHigh:  return 1'b1;
      SdaLow:   return 1'b0;
      SdaNoise: return 1'($urandom_range(1));
      SdaFlaky: return levels.ack_slot() ? ($urandom_range(9) == 0) : 1'($urandom_range(1));
      default:  return levels.ack_slot() ? 1'b0 : 1'($urandom_range(1));
    endcase
  endfunction

  function automatic sda_mode_e random_mode();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) return SdaSlave;
    if (r < 80) return SdaFlaky;
    if (r < 90) return SdaNoise;
    if (r < 95) return SdaHigh;
    return SdaLow;
  endfunction

  task automatic send_tick(input bit req, input bit op, input logic [7:0] ra,
                           input logic [7:0] wd, input sda_mode_e mode);
    bit sda;
    // now and then hold off until the output side has caught up
    if ($urandom_range(299) == 0 && levels.pending() != 0) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while (levels.pending() != 0);
    end
    while (!quiet && $urandom_range(99) < 16) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    sda = pick_sda(mode);
    in_valid_i         <= 1'b1;
    request_valid_i    <= req;
    opcode_i           <= op;
    register_address_i <= ra;
    write_data_i       <= wd;
    sda_sample_i       <= sda;
    do @(posedge clk_i); while (in_stall_o);
    levels.note_tick(req, op, ra, wd, sda);
  endtask

  // requests raised while busy must be ignored, so busy ticks carry random ones
  task automatic run_transaction(input bit op, input logic [7:0] ra, input logic [7:0] wd,
                                 input sda_mode_e mode);
    send_tick(1'b1, op, ra, wd, mode);
    while (!levels.seq_idle())
      send_tick(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
                8'($urandom_range(255)), mode);
    repeat ($urandom_range(3))
      send_tick(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)),
                8'($urandom_range(255)), mode);
  endtask

  task automatic configure(input logic [6:0] dev, input logic [7:0] tpp);
    in_valid_i <= 1'b0;
    while (levels.pending() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= i2c_ram_pkg::CfgDevAddr;
    cfg_data_i  <= {1'b0, dev};
    do @(posedge clk_i); while (!cfg_ready_o);
    levels.set_cfg(i2c_ram_pkg::CfgDevAddr, {1'b0, dev});
    cfg_index_i <= i2c_ram_pkg::CfgTpp;
    cfg_data_i  <= tpp;
    do @(posedge clk_i); while (!cfg_ready_o);
    levels.set_cfg(i2c_ram_pkg::CfgTpp, tpp);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // idle ticks under the reset defaults
    repeat (4)
      send_tick(1'b0, 1'($urandom_range(1)), 8'($urandom_range(255)),
                8'($urandom_range(255)), SdaSlave);
    // default device address at the fastest bus speed
    configure(i2c_ram_pkg::DevAddrReset, 8'd1);
    run_transaction(i2c_ram_pkg::OpWrite, 8'hFF, 8'h00, SdaSlave);
    // zero ticks per phase runs as one; slave never answers, every ack missed
    configure(7'd127, 8'd0);
    run_transaction(i2c_ram_pkg::OpRead, 8'hAA, 8'h55, SdaHigh);
    configure(7'h55, 8'd2);
    run_transaction(i2c_ram_pkg::OpWrite, 8'hA5, 8'h5A, SdaNoise);
    configure(7'($urandom_range(127)), 8'd1);
    run_transaction(i2c_ram_pkg::OpRead, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    random_mode());

    in_valid_i <= 1'b0;
    while (levels.pending() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (levels.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

@@ i2c_register_access_master.f @@
src/i2c_ram_pkg.sv
src/i2c_register_access_master.sv
test/tb.sv
